// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL files that carry concurrent checks.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property holds at every clock edge outside reset.
`define SSIT_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("ssit assertion failed");

// Consequent holds at the clock edge after the antecedent.
`define SSIT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ssit assertion failed");

`else

`define SSIT_ASSERT(lbl, prop)
`define SSIT_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== rtl/core/ssit_pkg.sv =====
// Package for the segment set intersection test unit: defaults, codes and
// the command/status structs between controller and datapath. No dependencies.
package ssit_pkg;

    localparam int MAX_SEGMENTS_DEFAULT = 64;
    localparam int COORD_BITS_DEFAULT   = 16;

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_LOAD  = 2'd1,
        CMD_TEST  = 2'd2
    } command_t;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_WALK   = 2'd1,
        ST_DRAIN  = 2'd2,
        ST_FINISH = 2'd3
    } state_t;

    typedef struct packed {
        logic clear;
        logic load;
        logic capture;
        logic walk;
        logic emit;
    } dp_cmd_t;

    typedef struct packed {
        logic empty;
        logic walk_end;
        logic pipe_busy;
        logic out_free;
        logic last;
    } dp_status_t;

endpackage

// ===== rtl/core/ssit_in_if.sv =====
// Input channel of the segment set intersection test unit: valid/ready and
// one command item. Depends on ssit_pkg.
interface ssit_in_if
    import ssit_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEFAULT
);
    logic                         valid;
    logic                         ready;
    logic [1:0]                   command;
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;
    logic                         last_query;

    modport source (
        output valid, command, start_x, start_y, end_x, end_y, last_query,
        input  ready
    );

    modport sink (
        input  valid, command, start_x, start_y, end_x, end_y, last_query,
        output ready
    );
endinterface

// ===== rtl/core/ssit_out_if.sv =====
// Result channel of the segment set intersection test unit: valid/ready and
// the two result flags. No dependencies.
interface ssit_out_if;
    logic valid;
    logic ready;
    logic any_crossing;
    logic overflowed;

    modport source (
        output valid, any_crossing, overflowed,
        input  ready
    );

    modport sink (
        input  valid, any_crossing, overflowed,
        output ready
    );
endinterface

// ===== rtl/core/ssit_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ssit_ram #(
    parameter int  WIDTH  = 64,
    parameter int  DEPTH  = 64,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/core/ssit_ctrl.sv =====
// Controller of the segment set intersection test unit: decodes commands and
// sequences the walk over the store. Depends on ssit_pkg.
module ssit_ctrl
    import ssit_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [1:0] in_command,
    output logic       in_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;
    logic   accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && (in_command == CMD_TEST))
                begin
                    state_next = status.empty ? ST_FINISH : ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (status.walk_end)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!status.pipe_busy)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!status.last || status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs.
    always_comb
    begin
        in_ready    = (state_reg == ST_IDLE);
        accept      = in_valid && in_ready;
        cmd.clear   = accept && (in_command == CMD_CLEAR);
        cmd.load    = accept && (in_command == CMD_LOAD);
        cmd.capture = accept && (in_command == CMD_TEST);
        cmd.walk    = (state_reg == ST_WALK);
        cmd.emit    = (state_reg == ST_FINISH) && status.last && status.out_free;
    end

endmodule

// ===== rtl/core/ssit_datapath.sv =====
// Datapath of the segment set intersection test unit: segment store, query
// register, orientation pipeline and result register. Depends on ssit_pkg, ssit_ram.
module ssit_datapath
    import ssit_pkg::*;
#(
    parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEFAULT,
    parameter int COORD_BITS   = COORD_BITS_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  dp_cmd_t                      cmd,
    output dp_status_t                   status,
    input  logic signed [COORD_BITS-1:0] start_x,
    input  logic signed [COORD_BITS-1:0] start_y,
    input  logic signed [COORD_BITS-1:0] end_x,
    input  logic signed [COORD_BITS-1:0] end_y,
    input  logic                         last_query,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         any_crossing,
    output logic                         overflowed
);

    localparam int C     = COORD_BITS;
    localparam int AW    = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int CW    = $clog2(MAX_SEGMENTS + 1);
    localparam int D     = C + 1;
    localparam int P     = 2 * D;
    localparam int X     = P + 1;
    localparam int SEG_W = 4 * C;

    // Control state.
    logic [CW-1:0] count_reg;
    logic          overflow_reg;
    logic          hit_reg;
    logic [AW-1:0] addr_reg;
    logic          v0_reg, v1_reg, v2_reg, v3_reg;
    logic          out_valid_reg;

    // Payload.
    logic signed [C-1:0] q_ax_reg, q_ay_reg, q_bx_reg, q_by_reg;
    logic                last_reg;
    logic                out_hit_reg, out_ovf_reg;
    logic signed [D-1:0] diff_reg  [12];
    logic signed [D-1:0] diff_next [12];
    logic signed [P-1:0] prod_reg  [8];
    logic signed [P-1:0] prod_next [8];
    logic signed [X-1:0] cross_val [4];
    logic [3:0]          neg_reg, zero_reg;
    logic [3:0]          neg_next, zero_next;

    logic [SEG_W-1:0]    wr_data;
    logic [SEG_W-1:0]    rd_data;
    logic signed [C-1:0] s_ax, s_ay, s_bx, s_by;
    logic                room;
    logic                crossing;
    logic [CW:0]         addr_inc;

    assign room     = (count_reg < CW'(MAX_SEGMENTS));
    assign wr_data  = {start_x, start_y, end_x, end_y};
    assign addr_inc = (CW+1)'(addr_reg) + (CW+1)'(1);

    ssit_ram #(
        .WIDTH (SEG_W),
        .DEPTH (MAX_SEGMENTS)
    ) u_store (
        .clk     (clk),
        .wr_en   (cmd.load && room),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (wr_data),
        .rd_en   (cmd.walk),
        .rd_addr (addr_reg),
        .rd_data (rd_data)
    );

    assign s_ax = rd_data[SEG_W-1 -: C];
    assign s_ay = rd_data[3*C-1 -: C];
    assign s_bx = rd_data[2*C-1 -: C];
    assign s_by = rd_data[C-1:0];

    // Coordinate differences for the four orientation tests.
    always_comb
    begin
        diff_next[0]  = D'(s_bx)     - D'(s_ax);
        diff_next[1]  = D'(s_by)     - D'(s_ay);
        diff_next[2]  = D'(q_ax_reg) - D'(s_ax);
        diff_next[3]  = D'(q_ay_reg) - D'(s_ay);
        diff_next[4]  = D'(q_bx_reg) - D'(s_ax);
        diff_next[5]  = D'(q_by_reg) - D'(s_ay);
        diff_next[6]  = D'(q_bx_reg) - D'(q_ax_reg);
        diff_next[7]  = D'(q_by_reg) - D'(q_ay_reg);
        diff_next[8]  = D'(s_ax)     - D'(q_ax_reg);
        diff_next[9]  = D'(s_ay)     - D'(q_ay_reg);
        diff_next[10] = D'(s_bx)     - D'(q_ax_reg);
        diff_next[11] = D'(s_by)     - D'(q_ay_reg);
    end

    // One multiplier per product, each path registered.
    always_comb
    begin
        prod_next[0] = diff_reg[0] * diff_reg[3];
        prod_next[1] = diff_reg[1] * diff_reg[2];
        prod_next[2] = diff_reg[0] * diff_reg[5];
        prod_next[3] = diff_reg[1] * diff_reg[4];
        prod_next[4] = diff_reg[6] * diff_reg[9];
        prod_next[5] = diff_reg[7] * diff_reg[8];
        prod_next[6] = diff_reg[6] * diff_reg[11];
        prod_next[7] = diff_reg[7] * diff_reg[10];
    end

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            cross_val[k] = X'(prod_reg[2*k]) - X'(prod_reg[2*k+1]);
            neg_next[k]  = cross_val[k][X-1];
            zero_next[k] = (cross_val[k] == '0);
        end
    end

    // Strict crossing: both pairs of orientations nonzero and opposite.
    assign crossing = !zero_reg[0] && !zero_reg[1] && (neg_reg[0] != neg_reg[1]) &&
                      !zero_reg[2] && !zero_reg[3] && (neg_reg[2] != neg_reg[3]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            overflow_reg  <= 1'b0;
            hit_reg       <= 1'b0;
            addr_reg      <= '0;
            v0_reg        <= 1'b0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear)
            begin
                count_reg    <= '0;
                overflow_reg <= 1'b0;
            end
            else if (cmd.load)
            begin
                if (room)
                begin
                    count_reg <= count_reg + CW'(1);
                end
                else
                begin
                    overflow_reg <= 1'b1;
                end
            end

            if (cmd.capture)
            begin
                addr_reg <= '0;
            end
            else if (cmd.walk)
            begin
                addr_reg <= addr_reg + AW'(1);
            end

            v0_reg <= cmd.walk;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;

            if (cmd.emit)
            begin
                hit_reg <= 1'b0;
            end
            else if (v3_reg && crossing)
            begin
                hit_reg <= 1'b1;
            end

            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            q_ax_reg <= start_x;
            q_ay_reg <= start_y;
            q_bx_reg <= end_x;
            q_by_reg <= end_y;
            last_reg <= last_query;
        end
        if (cmd.emit)
        begin
            out_hit_reg <= hit_reg;
            out_ovf_reg <= overflow_reg;
        end
        diff_reg <= diff_next;
        prod_reg <= prod_next;
        neg_reg  <= neg_next;
        zero_reg <= zero_next;
    end

    always_comb
    begin
        status.empty     = (count_reg == '0);
        status.walk_end  = (addr_inc == (CW+1)'(count_reg));
        status.pipe_busy = v0_reg || v1_reg || v2_reg || v3_reg;
        status.out_free  = !out_valid_reg || out_ready;
        status.last      = last_reg;
    end

    assign out_valid    = out_valid_reg;
    assign any_crossing = out_hit_reg;
    assign overflowed   = out_ovf_reg;

endmodule

// ===== rtl/core/segment_set_intersection_test_unit.sv =====
// Top level of the segment set intersection test unit.
// Depends on ssit_pkg, ssit_in_if, ssit_out_if, ssit_ctrl, ssit_datapath, assert_macros.svh.
//
// The unit keeps up to MAX_SEGMENTS line segments with signed COORD_BITS-bit
// endpoints and tests query segments against them. A clear transfer empties
// the set and drops the overflow flag; a load transfer appends one segment,
// or sets the overflow flag when the set is full; a test transfer checks the
// query for a strict crossing with every stored segment, using the signs of
// exact integer cross products, so touching, collinear and zero-length
// segments never count. Hits build up over a run of test transfers; the
// transfer with last_query set produces one result (any_crossing, overflowed)
// and clears the hit flag. Clear and load may follow each other every cycle.
// A test takes the transfer, reads each stored segment in turn from the single
// read port of the segment RAM, drains the pipeline behind it (read,
// difference, multiply, subtract, accumulate) and then finishes, handing over
// the result if last_query is set; on an empty set it skips the walk and the
// drain. The next transfer is taken as soon as the result sits in the output
// register, even if the sink has not yet taken it; a test ending a run waits
// only if the previous result is still held there. No clearing pass follows
// reset.
`include "assert_macros.svh"

module segment_set_intersection_test_unit
    import ssit_pkg::*;
#(
    parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEFAULT,
    parameter int COORD_BITS   = COORD_BITS_DEFAULT
) (
    input logic       clk,
    input logic       rst_n,
    ssit_in_if.sink   req,
    ssit_out_if.source rsp
);

    dp_cmd_t    cmd;
    dp_status_t status;

    // Sequence the commands and the walk; hold ready low while a test runs.
    ssit_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (req.valid),
        .in_command (req.command),
        .in_ready   (req.ready),
        .status     (status),
        .cmd        (cmd)
    );

    // Store segments, run the orientation pipeline, hold the result.
    ssit_datapath #(
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .COORD_BITS   (COORD_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .start_x      (req.start_x),
        .start_y      (req.start_y),
        .end_x        (req.end_x),
        .end_y        (req.end_y),
        .last_query   (req.last_query),
        .out_valid    (rsp.valid),
        .out_ready    (rsp.ready),
        .any_crossing (rsp.any_crossing),
        .overflowed   (rsp.overflowed)
    );

    // Never overwrite a result that the sink has not taken.
    `SSIT_ASSERT(a_emit_into_free_slot, !cmd.emit || status.out_free)
    // Never read the store when it holds nothing.
    `SSIT_ASSERT(a_walk_not_empty, !cmd.walk || !status.empty)
    // Keep the input closed while segments are still in flight.
    `SSIT_ASSERT(a_busy_blocks_input, !status.pipe_busy || !req.ready)
    // Present the result on the cycle after it is produced.
    `SSIT_ASSERT_NEXT(a_emit_shows_result, cmd.emit, rsp.valid)

endmodule

// ===== tb/segment_set_intersection_test_unit_test.sv =====
// Testbench for segment_set_intersection_test_unit: directed and random command streams,
// with a self-contained segment-crossing predictor and an in-order result checker.
// Depends on ssit_pkg, ssit_in_if, ssit_out_if and the unit itself.
`timescale 1ns / 1ps

module segment_set_intersection_test_unit_test;
    import ssit_pkg::*;

    localparam int MAX_SEGMENTS = MAX_SEGMENTS_DEFAULT;
    localparam int COORD_BITS   = COORD_BITS_DEFAULT;
    // Command code that the unit must ignore.
    localparam logic [1:0] CMD_RESERVED = 2'd3;
    localparam int RANDOM_ITEMS  = 340;
    // Allow a full walk plus margin.
    localparam int SETTLE_CYCLES = MAX_SEGMENTS + 16;
    // Slowest run: ~450 transfers, each with a full walk, a gap and a long sink stall, several times over.
    localparam int CYCLE_LIMIT   = 400000;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        coord_t ax;
        coord_t ay;
        coord_t bx;
        coord_t by;
    } segment_t;

    typedef struct packed {
        logic any_crossing;
        logic overflowed;
    } verdict_t;

    logic clk;
    logic rst_n;

    ssit_in_if #(.COORD_BITS(COORD_BITS)) req_if ();
    ssit_out_if rsp_if ();

    segment_set_intersection_test_unit #(
        .MAX_SEGMENTS(MAX_SEGMENTS),
        .COORD_BITS  (COORD_BITS)
    ) dut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req_if),
        .rsp  (rsp_if)
    );

    // Predictor state: our own copy of the stored set and the two sticky flags.
    segment_t    stored_segments [MAX_SEGMENTS];
    int unsigned stored_count;
    bit          hit_seen;
    bit          overflow_seen;

    // Verdicts predicted at each run-ending test transfer, oldest first.
    verdict_t    pending_verdicts [$];

    int          failures;
    int unsigned cycle_count;
    int          burst_left;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Geometry: sign of the exact cross product (q - p) x (r - p).
    // Differences fit in 17 bits, products in 34, so longint is exact.
    // ------------------------------------------------------------------
    function automatic int orientation(longint px, longint py, longint qx, longint qy,
                                       longint rx, longint ry);
        longint cp;
        cp = (qx - px) * (ry - py) - (qy - py) * (rx - px);
        return (cp > 0) ? 1 : ((cp < 0) ? -1 : 0);
    endfunction

    // Strict crossing only: any zero orientation (touch, collinear, point) is a miss.
    function automatic bit strictly_cross(segment_t s, segment_t t);
        int o1;
        int o2;
        int o3;
        int o4;
        o1 = orientation(s.ax, s.ay, s.bx, s.by, t.ax, t.ay);
        o2 = orientation(s.ax, s.ay, s.bx, s.by, t.bx, t.by);
        if (o1 == 0 || o2 == 0 || o1 == o2)
            return 1'b0;
        o3 = orientation(t.ax, t.ay, t.bx, t.by, s.ax, s.ay);
        o4 = orientation(t.ax, t.ay, t.bx, t.by, s.bx, s.by);
        if (o3 == 0 || o4 == 0 || o3 == o4)
            return 1'b0;
        return 1'b1;
    endfunction

    // Advance the predictor by one accepted transfer.
    task automatic predict_verdict(logic [1:0] cmd, segment_t seg, logic last);
        verdict_t v;
        if (cmd == CMD_CLEAR)
        begin
            // Clear drops the set and the overflow flag; the hit flag survives.
            stored_count  = 0;
            overflow_seen = 1'b0;
        end
        else if (cmd == CMD_LOAD)
        begin
            if (stored_count < MAX_SEGMENTS)
            begin
                stored_segments[stored_count] = seg;
                stored_count++;
            end
            else
                overflow_seen = 1'b1;
        end
        else if (cmd == CMD_TEST)
        begin
            for (int i = 0; i < stored_count; i++)
                if (strictly_cross(stored_segments[i], seg))
                    hit_seen = 1'b1;
            if (last)
            begin
                v.any_crossing = hit_seen;
                v.overflowed   = overflow_seen;
                pending_verdicts = {pending_verdicts, v};
                hit_seen = 1'b0;
            end
        end
        // The reserved code changes nothing.
    endtask

    // ------------------------------------------------------------------
    // Sender: bursts of back-to-back transfers separated by random gaps.
    // Drive at the falling edge, detect the transfer at the rising edge.
    // ------------------------------------------------------------------
    task automatic send_segment(logic [1:0] cmd, segment_t seg, logic last);
        int gap;
        if (burst_left <= 0)
        begin
            // A quarter of the bursts follow on without any gap.
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 40);
            if (gap > 0)
            begin
                @(negedge clk);
                req_if.valid = 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        @(negedge clk);
        req_if.command    = cmd;
        req_if.start_x    = seg.ax;
        req_if.start_y    = seg.ay;
        req_if.end_x      = seg.bx;
        req_if.end_y      = seg.by;
        req_if.last_query = last;
        req_if.valid      = 1'b1;
        @(posedge clk);
        while (req_if.ready !== 1'b1)
            @(posedge clk);
        predict_verdict(cmd, seg, last);
        burst_left--;
    endtask

    task automatic send_cmd(logic [1:0] cmd, int sx, int sy, int ex, int ey, logic last);
        segment_t seg;
        seg.ax = coord_t'(sx);
        seg.ay = coord_t'(sy);
        seg.bx = coord_t'(ex);
        seg.by = coord_t'(ey);
        send_segment(cmd, seg, last);
    endtask

    // Hold the sender until every predicted verdict has come back.
    task automatic wait_drained();
        @(negedge clk);
        req_if.valid = 1'b0;
        burst_left   = 0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
    endtask

    // Coordinate styles: full range, a tiny grid (collinear and touching cases
    // become frequent), or the extremes of the signed range, zero and -1.
    function automatic coord_t random_coord(int unsigned style);
        int v;
        case (style)
            0:       v = $urandom();
            1:       v = $urandom_range(0, 16) - 8;
            default:
            begin
                case ($urandom_range(0, 3))
                    0:       v = -32768;
                    1:       v = 32767;
                    2:       v = 0;
                    default: v = -1;
                endcase
            end
        endcase
        return coord_t'(v);
    endfunction

    function automatic segment_t random_segment();
        segment_t    seg;
        int unsigned style;
        case ($urandom_range(0, 5))
            0, 1:    style = 0;
            5:       style = 2;
            default: style = 1;
        endcase
        seg.ax = random_coord(style);
        seg.ay = random_coord(style);
        seg.bx = random_coord(style);
        seg.by = random_coord(style);
        return seg;
    endfunction

    // ------------------------------------------------------------------
    // Receiver: switch between random stall patterns over random spans.
    // ------------------------------------------------------------------
    initial
    begin
        int unsigned mode;
        int unsigned span;
        int unsigned phase;
        phase        = 0;
        rsp_if.ready = 1'b0;
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(20, 150);
            repeat (span)
            begin
                @(negedge clk);
                phase++;
                case (mode)
                    0:       rsp_if.ready = 1'b1;
                    1:       rsp_if.ready = 1'($urandom_range(0, 1));
                    2:       rsp_if.ready = ($urandom_range(0, 3) == 0);
                    default: rsp_if.ready = (phase % 3 != 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Checker: compare each result transfer with the oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        verdict_t want;
        if (rst_n && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
        begin
            if (pending_verdicts.size() == 0)
            begin
                failures++;
                $error("unexpected result: any_crossing=%0b overflowed=%0b",
                       rsp_if.any_crossing, rsp_if.overflowed);
            end
            else
            begin
                want = pending_verdicts.pop_front();
                if (rsp_if.any_crossing !== want.any_crossing)
                begin
                    failures++;
                    $error("any_crossing: expected %0b, got %0b",
                           want.any_crossing, rsp_if.any_crossing);
                end
                if (rsp_if.overflowed !== want.overflowed)
                begin
                    failures++;
                    $error("overflowed: expected %0b, got %0b",
                           want.overflowed, rsp_if.overflowed);
                end
            end
        end
    end

    // Watchdog: drop the run if it hangs.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------

    // A test on the set left empty by reset is a miss with no overflow.
    task automatic test_empty_set();
        send_cmd(CMD_TEST, 0, -5, 0, 5, 1'b1);
    endtask

    // Proper crossing, endpoint touch, collinear overlap, point and parallel.
    task automatic test_crossing_cases();
        send_cmd(CMD_CLEAR, 0, 0, 0, 0, 1'b0);
        send_cmd(CMD_LOAD, -100, 0, 100, 0, 1'b0);
        send_cmd(CMD_TEST, 0, -100, 0, 100, 1'b1);
        send_cmd(CMD_TEST, 0, 0, 0, 100, 1'b1);
        send_cmd(CMD_TEST, -50, 0, 50, 0, 1'b1);
        send_cmd(CMD_TEST, 0, 0, 0, 0, 1'b1);
        send_cmd(CMD_TEST, -100, 1, 100, 1, 1'b1);
    endtask

    // Full-range diagonals: widest differences and products.
    task automatic test_coordinate_extremes();
        send_cmd(CMD_CLEAR, 0, 0, 0, 0, 1'b0);
        send_cmd(CMD_LOAD, -32768, -32768, 32767, 32767, 1'b0);
        send_cmd(CMD_TEST, -32768, 32767, 32767, -32768, 1'b1);
        send_cmd(CMD_TEST, 32767, -32768, -32768, 32767, 1'b1);
    endtask

    // A hit in the middle of a run holds until the run ends, then clears.
    task automatic test_hit_accumulation();
        send_cmd(CMD_TEST, -100, 5, 100, 5, 1'b0);
        send_cmd(CMD_TEST, -100, 100, 100, -100, 1'b0);
        send_cmd(CMD_TEST, 200, 0, 300, 0, 1'b1);
        send_cmd(CMD_TEST, 200, 0, 300, 0, 1'b1);
    endtask

    // Reserved code and last_query on clear/load give nothing; clear keeps the hit flag.
    task automatic test_ignored_items();
        send_cmd(CMD_RESERVED, -32768, 32767, -1, 0, 1'b1);
        send_cmd(CMD_LOAD, 10, -10, 10, 10, 1'b1);
        send_cmd(CMD_TEST, 0, 0, 20, 0, 1'b0);
        send_cmd(CMD_CLEAR, 0, 0, 0, 0, 1'b1);
        send_cmd(CMD_TEST, 0, 0, 20, 0, 1'b1);
    endtask

    // Fill the set, drop one more load, then see the flag fall at clear.
    task automatic test_store_overflow();
        send_cmd(CMD_CLEAR, 0, 0, 0, 0, 1'b0);
        repeat (MAX_SEGMENTS)
            send_segment(CMD_LOAD, random_segment(), 1'b0);
        send_cmd(CMD_LOAD, 0, -1000, 0, 1000, 1'b0);
        send_cmd(CMD_TEST, -1000, 0, 1000, 0, 1'b1);
        send_cmd(CMD_CLEAR, 0, 0, 0, 0, 1'b0);
        send_cmd(CMD_TEST, -1000, 0, 1000, 0, 1'b1);
    endtask

    // ------------------------------------------------------------------
    // Random sessions: mostly a clear, a handful of loads, then runs of tests.
    // Some sessions fill past capacity; noise and broken runs mixed in.
    // ------------------------------------------------------------------
    task automatic test_random_sessions();
        int       sent;
        int       load_total;
        int       run_total;
        int       run_len;
        int       pick;
        segment_t seg;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 4) != 0)
            begin
                send_segment(CMD_CLEAR, random_segment(), 1'($urandom_range(0, 1)));
                sent++;
            end
            load_total = ($urandom_range(0, 11) == 0) ?
                         $urandom_range(MAX_SEGMENTS - 4, MAX_SEGMENTS + 6) :
                         $urandom_range(0, 8);
            for (int i = 0; i < load_total; i++)
            begin
                send_segment(CMD_LOAD, random_segment(), $urandom_range(0, 7) == 0);
                sent++;
            end
            run_total = $urandom_range(1, 3);
            for (int r = 0; r < run_total; r++)
            begin
                run_len = $urandom_range(1, 4);
                for (int j = 0; j < run_len; j++)
                begin
                    // Break the run now and then with a stray load or clear.
                    if ($urandom_range(0, 9) == 0)
                    begin
                        send_segment($urandom_range(0, 1) ? CMD_LOAD : CMD_CLEAR,
                                     random_segment(), 1'b0);
                        sent++;
                    end
                    if ($urandom_range(0, 7) == 0)
                        send_segment(CMD_RESERVED, random_segment(),
                                     1'($urandom_range(0, 1)));
                    seg = random_segment();
                    // Start on a stored endpoint so touching cases come up.
                    if (stored_count > 0 && $urandom_range(0, 5) == 0)
                    begin
                        pick   = $urandom_range(0, stored_count - 1);
                        seg.ax = stored_segments[pick].bx;
                        seg.ay = stored_segments[pick].by;
                    end
                    send_segment(CMD_TEST, seg, j == run_len - 1);
                    sent++;
                end
            end
            if ($urandom_range(0, 15) == 0)
                wait_drained();
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n             = 1'b0;
        req_if.valid      = 1'b0;
        req_if.command    = CMD_CLEAR;
        req_if.start_x    = '0;
        req_if.start_y    = '0;
        req_if.end_x      = '0;
        req_if.end_y      = '0;
        req_if.last_query = 1'b0;
        stored_count      = 0;
        hit_seen          = 1'b0;
        overflow_seen     = 1'b0;
        failures          = 0;
        cycle_count       = 0;
        burst_left        = 0;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_empty_set();
        test_crossing_cases();
        wait_drained();
        test_coordinate_extremes();
        test_hit_accumulation();
        wait_drained();
        test_ignored_items();
        test_store_overflow();
        wait_drained();
        test_random_sessions();

        // Drain, then give a full walk's time for any stray result to show up.
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (failures == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
